// ===== hw/rtl/stc_pkg.sv =====
// shared types and constants for the shift-jis text to tile command block
// no dependencies; imported by every module of the block

package stc_pkg;

  localparam int CELL_TILES = 1;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SELECT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ATTRIBUTES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROW        = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_ENABLE      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ASCII_FONT_BASE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_ROW_STRIDE = 4'd7;

  localparam logic [11:0] FONT_ROW_STRIDE_RESET = 12'd752;

  // byte codes
  localparam logic [7:0] LEAD_LO_MIN  = 8'h81;
  localparam logic [7:0] LEAD_LO_MAX  = 8'h9F;
  localparam logic [7:0] LEAD_HI_MIN  = 8'hE0;
  localparam logic [7:0] LEAD_HI_MAX  = 8'hEF;
  localparam logic [7:0] TRAIL_BASE   = 8'h40;
  localparam logic [7:0] TRAIL_SKIP   = 8'h7E;
  localparam logic [7:0] TRAIL_BASE_2 = 8'h41;
  localparam logic [7:0] TRAIL_ODD    = 8'h9F;
  localparam logic [7:0] ASCII_FIRST  = 8'h20;
  localparam logic [7:0] ASCII_LAST   = 8'h7E;
  localparam logic [7:0] ROW_HI_EVEN  = 8'd62;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_ASCII = 1'b1;

  typedef struct packed {
    logic        plane_select;
    logic [10:0] start_pattern;
    logic [4:0]  tile_attributes;
    logic [15:0] start_column;
    logic [15:0] text_row;
    logic        dma_enable;
    logic [10:0] ascii_font_base;
    logic [11:0] font_row_stride;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        string_start;
  } item_t;

  typedef struct packed {
    logic [7:0]  pending_lead;
    logic        lead_held;
    logic [15:0] cursor_column;
    logic [10:0] pattern_counter;
  } state_t;

  typedef struct packed {
    logic        command_kind;
    logic        target_plane;
    logic [15:0] map_entry;
    logic [15:0] map_column;
    logic [15:0] map_row;
    logic [17:0] font_word_offset;
    logic [10:0] dest_pattern;
    logic        use_dma_out;
  } result_t;

endpackage

// ===== hw/rtl/stc_cfg_regs.sv =====
// configuration register file of the text to tile command block
// depends on stc_pkg

module stc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data,
  output stc_pkg::cfg_t                 cfg
);
  import stc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_select    <= 1'b0;
      cfg.start_pattern   <= '0;
      cfg.tile_attributes <= '0;
      cfg.start_column    <= '0;
      cfg.text_row        <= '0;
      cfg.dma_enable      <= 1'b0;
      cfg.ascii_font_base <= '0;
      cfg.font_row_stride <= FONT_ROW_STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_SELECT:    cfg.plane_select    <= cfg_data[0];
        REG_START_PATTERN:   cfg.start_pattern   <= cfg_data[10:0];
        REG_TILE_ATTRIBUTES: cfg.tile_attributes <= cfg_data[4:0];
        REG_START_COLUMN:    cfg.start_column    <= cfg_data;
        REG_TEXT_ROW:        cfg.text_row        <= cfg_data;
        REG_DMA_ENABLE:      cfg.dma_enable      <= cfg_data[0];
        REG_ASCII_FONT_BASE: cfg.ascii_font_base <= cfg_data[10:0];
        REG_FONT_ROW_STRIDE: cfg.font_row_stride <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stc_decode.sv =====
// byte decode: lead/trail pairing, jis row and column, font offset, map entry
// depends on stc_pkg; purely combinational, state registers live in the top level

module stc_decode (
  input  stc_pkg::cfg_t    cfg,
  input  stc_pkg::item_t   item,
  input  stc_pkg::state_t  state,
  output stc_pkg::state_t  state_next,
  output logic             emit,
  output stc_pkg::result_t result
);
  import stc_pkg::*;

  logic        held;
  logic [15:0] cursor;
  logic [10:0] pattern;
  logic [7:0]  b;
  logic [7:0]  lead;
  logic        is_lead;
  logic        is_ascii;
  logic        odd_row;
  logic [7:0]  row8;
  logic [6:0]  row;
  logic [7:0]  col;
  logic [18:0] prod;
  logic [17:0] offset;
  logic [10:0] ascii_tile;

  always_comb begin
    b       = item.text_byte;
    lead    = state.pending_lead;
    held    = item.string_start ? 1'b0 : state.lead_held;
    cursor  = item.string_start ? cfg.start_column : state.cursor_column;
    pattern = item.string_start ? cfg.start_pattern : state.pattern_counter;

    is_lead  = ((b >= LEAD_LO_MIN) && (b <= LEAD_LO_MAX)) ||
               ((b >= LEAD_HI_MIN) && (b <= LEAD_HI_MAX));
    is_ascii = (b >= ASCII_FIRST) && (b <= ASCII_LAST);

    // jis row from the held lead, odd row when trail is at or above 0x9f
    odd_row = (b >= TRAIL_ODD);
    if (lead <= LEAD_LO_MAX) begin
      row8 = 8'((lead - LEAD_LO_MIN) << 1);
    end else begin
      row8 = 8'(8'((lead - LEAD_HI_MIN) << 1) + ROW_HI_EVEN);
    end
    row = row8[6:0] + {6'd0, odd_row};

    // column skips the 0x7f hole on even rows
    if (odd_row) begin
      col = b - TRAIL_ODD;
    end else if (b <= TRAIL_SKIP) begin
      col = b - TRAIL_BASE;
    end else begin
      col = b - TRAIL_BASE_2;
    end

    prod       = 19'(row) * 19'(cfg.font_row_stride);
    offset     = prod[17:0] + {7'd0, col, 3'b000};
    ascii_tile = cfg.ascii_font_base + {3'd0, 8'(b - ASCII_FIRST)};

    state_next.pending_lead    = lead;
    state_next.lead_held       = held;
    state_next.cursor_column   = cursor;
    state_next.pattern_counter = pattern;

    result.command_kind     = KIND_GLYPH;
    result.target_plane     = cfg.plane_select;
    result.map_entry        = {cfg.tile_attributes, pattern};
    result.map_column       = cursor;
    result.map_row          = cfg.text_row;
    result.font_word_offset = offset;
    result.dest_pattern     = pattern;
    result.use_dma_out      = cfg.dma_enable;
    emit = 1'b0;

    if (held) begin
      state_next.pending_lead = '0;
      state_next.lead_held    = 1'b0;
      // dangling lead before a terminator is dropped
      if (b != 8'h00) begin
        emit = 1'b1;
        state_next.pattern_counter = pattern + 11'(CELL_TILES);
        state_next.cursor_column   = cursor + 16'd1;
      end
    end else if (is_lead) begin
      state_next.pending_lead = b;
      state_next.lead_held    = 1'b1;
    end else if (is_ascii) begin
      emit = 1'b1;
      state_next.cursor_column = cursor + 16'd1;
      result.command_kind      = KIND_ASCII;
      result.map_entry         = {cfg.tile_attributes, ascii_tile};
      result.font_word_offset  = '0;
      result.dest_pattern      = '0;
      result.use_dma_out       = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/stc_out_reg.sv =====
// result register of the text to tile command block, holds one beat for the master side
// depends on stc_pkg

module stc_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           load_valid,
  input  stc_pkg::result_t               result,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [stc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import stc_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= load_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      held <= result;
    end
  end

  assign m_tuser = held.command_kind;
  assign m_tdata = {1'b0, held.use_dma_out, held.dest_pattern, held.font_word_offset,
                    held.map_row, held.map_column, held.map_entry, held.target_plane};

endmodule

// ===== hw/rtl/sjis_text_to_tile_commands.sv =====
// top level of the shift-jis text to tile command block
// depends on stc_pkg, stc_cfg_regs, stc_decode, stc_out_reg
//
// usage:
//   slave side takes one text byte per beat: s_tdata is the byte, s_tuser is the
//   string start flag (cursor, pattern counter and held lead are reloaded first)
//   master side gives at most one command per byte: m_tuser is the command kind
//   (0 glyph tile load plus map fill, 1 ascii map write), m_tdata the payload
//   configuration is written through cfg_we / cfg_index / cfg_data while idle
// timing:
//   a byte is registered on accept and decoded combinationally; its command enters
//   the result register, raising m_tvalid, when the item advances
//   one byte per cycle with m_tready high; decode: 7 x 12 bit multiply plus an add
//   lead bytes, control bytes and dropped leads give no beat on the master side
// reset and stall:
//   rst clears the registers, the cursor, the pattern counter and the held lead;
//   the font row stride resets to 752
//   while m_tready is low and a command waits, the input register holds and
//   s_tready falls once it is full; no beat is lost or repeated

module sjis_text_to_tile_commands (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [stc_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] text_byte
  input  logic                            s_tuser,  // [0] string_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] target_plane, [16:1] map_entry, [32:17] map_column, [48:33] map_row,
  // [66:49] font_word_offset, [77:67] dest_pattern, [78] use_dma_out, [79] zero
  output logic [stc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser,  // [0] command_kind
  input  logic                            cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import stc_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  state_t  state;
  state_t  state_next;
  logic    emit;
  result_t result;
  logic    advance;

  stc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.text_byte    <= s_tdata;
      item.string_start <= s_tuser;
    end
  end

  stc_decode u_decode (
    .cfg        (cfg),
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  // decoder state moves only when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  stc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .load_valid (emit),
    .result     (result),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
